FILE: sv/swq_pkg.sv
// shared constants, codes and types for the sliding window or queue
`default_nettype none

package swq_pkg;

   localparam int DEPTH   = 64;
   localparam int DATA_W  = 32;
   localparam int VALUE_W = 32;
   localparam int OR_W    = 32;
   localparam int OCC_W   = 7;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);

   localparam logic [PTR_W:0] SLOT_LIMIT = (PTR_W + 1)'(DEPTH);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic push;
      logic pop_empty;
      logic pop_commit;
      logic xfer_start;
      logic xfer_issue;
      logic xfer_commit;
      logic pop_rsp;
   } swq_cmd_type;

   typedef struct packed {
      logic empty;
      logic front_empty;
      logic pos_zero;
      logic out_free;
   } swq_stat_type;

   // circular slot arithmetic, offset below DEPTH
   function automatic logic [PTR_W-1:0] wrap_slot(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] offs);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= SLOT_LIMIT) begin
         sum = sum - SLOT_LIMIT;
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: sv/swq_req_if.sv
// request channel interface
`default_nettype none

interface swq_req_if import swq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

FILE: sv/swq_rsp_if.sv
// response channel interface
`default_nettype none

interface swq_rsp_if import swq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OR_W-1:0]  window_or;
   logic [OCC_W-1:0] occupancy;
   logic [1:0]       status;

   modport source (output valid, output window_or, output occupancy, output status,
                   input ready);
   modport sink   (input valid, input window_or, input occupancy, input status,
                   output ready);
endinterface

`default_nettype wire

FILE: sv/sliding_window_or_queue.sv
// top level of the sliding window or queue
//
//   channel    dir   payload                          transfer when
//   req_chan   in    req_type, value                  valid && ready
//   rsp_chan   out   window_or, occupancy, status     valid && ready
//
// a push, a refused push or a pop on empty gives its result in the cycle after the transfer
// a pop from a filled front segment steps through commit, front store read and result
// a pop that finds the front segment empty first walks the n back entries through the
// single read port of the value store
// synchronous reset clears the counters and the back or; the stores need no clearing
// a new request is taken in idle whenever the response register is empty or being drained
`default_nettype none

module sliding_window_or_queue import swq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   swq_req_if.sink   req_chan,
   swq_rsp_if.source rsp_chan
);

   swq_cmd_type  cmd;
   swq_stat_type stat;

   swq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   swq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .push_value    (req_chan.value),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_window_or (rsp_chan.window_or),
      .rsp_occupancy (rsp_chan.occupancy),
      .rsp_status    (rsp_chan.status)
   );

endmodule

`default_nettype wire

FILE: sv/swq_ctrl.sv
// controller state machine for the sliding window or queue
`default_nettype none

module swq_ctrl import swq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_type,
   output logic         req_ready,
   input  swq_stat_type stat,
   output swq_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_XFER    = 5'b00010,
      S_DRAIN   = 5'b00100,
      S_POP_RD  = 5'b01000,
      S_POP_OUT = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               if (req_type == OP_PUSH) begin
                  cmd.push = 1'b1;
               end else if (stat.empty) begin
                  cmd.pop_empty = 1'b1;
               end else if (stat.front_empty) begin
                  cmd.xfer_start = 1'b1;
                  state_in       = S_XFER;
               end else begin
                  cmd.pop_commit = 1'b1;
                  state_in       = S_POP_RD;
               end
            end
         end
         S_XFER: begin
            cmd.xfer_issue = 1'b1;
            if (stat.pos_zero) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.xfer_commit = 1'b1;
            state_in        = S_POP_RD;
         end
         S_POP_RD: begin
            state_in = S_POP_OUT;
         end
         S_POP_OUT: begin
            if (stat.out_free) begin
               cmd.pop_rsp = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_xfer_enters_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_XFER && stat.pos_zero) |=> state_ff == S_DRAIN)
      else $error("transfer loop did not reach drain");

   a_pop_reads_first: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_commit || cmd.xfer_commit) |=> state_ff == S_POP_RD)
      else $error("pop commit not followed by front read");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ($past(state_in) == S_IDLE || $past(reset)
         || state_ff == S_IDLE))
      else $error("request transfer outside idle");

endmodule

`default_nettype wire

FILE: sv/swq_dp.sv
// datapath: value store, front or store, counters and response register
`default_nettype none

module swq_dp import swq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [VALUE_W-1:0] push_value,
   input  swq_cmd_type        cmd,
   output swq_stat_type       stat,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [OR_W-1:0]    rsp_window_or,
   output logic [OCC_W-1:0]   rsp_occupancy,
   output logic [1:0]         rsp_status
);

   logic [DATA_W-1:0] held_mem  [DEPTH];
   logic [DATA_W-1:0] front_mem [DEPTH];

   logic [PTR_W-1:0]  oldest_ff, oldest_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  front_ff, front_in;
   logic [DATA_W-1:0] back_or_ff, back_or_in;
   logic [PTR_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              wb_en_ff, wb_en_in;
   logic [PTR_W-1:0]  wb_slot_ff, wb_slot_in;
   logic [DATA_W-1:0] held_rd_ff;
   logic [DATA_W-1:0] fr_rd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_or_ff, rsp_or_in;
   logic [CNT_W-1:0]  rsp_occ_ff, rsp_occ_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic [DATA_W-1:0] value_w;
   logic [DATA_W-1:0] front_part;
   logic [DATA_W-1:0] wb_acc;
   logic [PTR_W-1:0]  tail_slot;
   logic [PTR_W-1:0]  rd_slot;
   logic [PTR_W-1:0]  next_oldest;
   logic              full;
   logic              push_write;

   assign value_w     = DATA_W'(push_value);
   assign full        = (total_ff == CNT_W'(DEPTH));
   assign push_write  = cmd.push && !full;
   assign tail_slot   = wrap_slot(oldest_ff, PTR_W'(total_ff));
   assign rd_slot     = wrap_slot(oldest_ff, pos_ff);
   assign next_oldest = wrap_slot(oldest_ff, PTR_W'(1));
   assign front_part  = (front_ff == '0) ? '0 : fr_rd_ff;
   assign wb_acc      = acc_ff | held_rd_ff;

   assign stat.empty       = (total_ff == '0);
   assign stat.front_empty = (front_ff == '0);
   assign stat.pos_zero    = (pos_ff == '0);
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      oldest_in     = oldest_ff;
      total_in      = total_ff;
      front_in      = front_ff;
      back_or_in    = back_or_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      wb_en_in      = 1'b0;
      wb_slot_in    = wb_slot_ff;
      rsp_or_in     = rsp_or_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (wb_en_ff) begin
         acc_in = wb_acc;
      end

      if (cmd.push) begin
         rsp_valid_in = 1'b1;
         if (full) begin
            rsp_or_in     = back_or_ff | front_part;
            rsp_occ_in    = total_ff;
            rsp_status_in = ST_FULL;
         end else begin
            total_in      = total_ff + CNT_W'(1);
            back_or_in    = back_or_ff | value_w;
            rsp_or_in     = back_or_ff | value_w | front_part;
            rsp_occ_in    = total_ff + CNT_W'(1);
            rsp_status_in = ST_DONE;
         end
      end

      if (cmd.pop_empty) begin
         rsp_valid_in  = 1'b1;
         rsp_or_in     = '0;
         rsp_occ_in    = '0;
         rsp_status_in = ST_EMPTY;
      end

      if (cmd.pop_commit) begin
         oldest_in = next_oldest;
         front_in  = front_ff - CNT_W'(1);
         total_in  = total_ff - CNT_W'(1);
      end

      if (cmd.xfer_start) begin
         pos_in = PTR_W'(total_ff - CNT_W'(1));
         acc_in = '0;
      end

      if (cmd.xfer_issue) begin
         pos_in     = pos_ff - PTR_W'(1);
         wb_en_in   = 1'b1;
         wb_slot_in = rd_slot;
      end

      if (cmd.xfer_commit) begin
         oldest_in  = next_oldest;
         front_in   = total_ff - CNT_W'(1);
         total_in   = total_ff - CNT_W'(1);
         back_or_in = '0;
      end

      if (cmd.pop_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_or_in     = back_or_ff | front_part;
         rsp_occ_in    = total_ff;
         rsp_status_in = ST_DONE;
      end
   end

   // value store: one write port, one read port for the transfer walk
   always_ff @(posedge clock) begin
      if (push_write) begin
         held_mem[tail_slot] <= value_w;
      end
      held_rd_ff <= held_mem[rd_slot];
   end

   // front running or store, read at the oldest slot
   always_ff @(posedge clock) begin
      if (wb_en_ff) begin
         front_mem[wb_slot_ff] <= wb_acc;
      end
      fr_rd_ff <= front_mem[oldest_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         total_ff     <= '0;
         front_ff     <= '0;
         back_or_ff   <= '0;
         wb_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         oldest_ff    <= oldest_in;
         total_ff     <= total_in;
         front_ff     <= front_in;
         back_or_ff   <= back_or_in;
         wb_en_ff     <= wb_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      acc_ff        <= acc_in;
      wb_slot_ff    <= wb_slot_in;
      rsp_or_ff     <= rsp_or_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_window_or = OR_W'(rsp_or_ff);
   assign rsp_occupancy = OCC_W'(rsp_occ_ff);
   assign rsp_status    = rsp_status_ff;

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      front_ff <= total_ff && total_ff <= CNT_W'(DEPTH))
      else $error("front or total count out of range");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push_write |=> total_ff == $past(total_ff) + CNT_W'(1))
      else $error("accepted push did not grow the count");

   a_drain_clears_back: assert property (@(posedge clock) disable iff (reset)
      cmd.xfer_commit |=> (back_or_ff == '0 && front_ff == total_ff))
      else $error("transfer left entries in the back segment");

   a_issue_writes_back: assert property (@(posedge clock) disable iff (reset)
      cmd.xfer_issue |=> wb_en_ff)
      else $error("transfer read without write back");

endmodule

`default_nettype wire
